[rtl/rmvi_pkg.sv]
`timescale 1ns / 1ps
// shared constants, codes and types of the regression imputer
package rmvi_pkg;

  localparam int MAX_RECORDS    = 8;
  localparam int NUM_ATTRIBUTES = 5;
  localparam int CELLS          = MAX_RECORDS * NUM_ATTRIBUTES;

  localparam int CELL_W = 32;
  localparam int CFG_W  = 4;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int CNT_W  = $clog2(CELLS + 1);
  localparam int ROW_W  = $clog2(MAX_RECORDS + 1);
  localparam int COL_W  = $clog2(NUM_ATTRIBUTES);
  localparam int SUM_W  = CELL_W + $clog2(MAX_RECORDS) + 1;
  localparam int WIDE_W = 112;
  localparam int DCNT_W = $clog2(WIDE_W + 1);

  localparam int APB_AW = 3;
  localparam int APB_DW = 32;
  localparam logic [APB_AW-3:0] REG_RECORD_COUNT = '0;
  localparam logic [CFG_W-1:0]  RECORD_COUNT_RST = CFG_W'(8);

  typedef enum logic [1:0] {
    CAP_NONE,
    CAP_Y,
    CAP_X,
    CAP_XR
  } cap_e;

  typedef enum logic [3:0] {
    MOP_XY,
    MOP_XX,
    MOP_NSXX,
    MOP_SXSX,
    MOP_NSXY,
    MOP_SXSY,
    MOP_NXR,
    MOP_NT,
    MOP_SYD,
    MOP_ND
  } mop_e;

  typedef enum logic [3:0] {
    WB_NONE,
    WB_SXY,
    WB_SXX,
    WB_TMP,
    WB_DSUB,
    WB_NSUB,
    WB_T,
    WB_NUM,
    WB_DEN
  } wb_e;

  typedef enum logic {
    WSEL_IN,
    WSEL_QUO
  } wsel_e;

  typedef struct packed {
    logic              ram_we;
    wsel_e             wsel;
    logic [ADDR_W-1:0] ram_addr;
    cap_e              cap;
    logic              clr_fit;
    logic              acc_row;
    logic              mul_start;
    mop_e              mop;
    wb_e               wb;
    logic              div_start;
    logic              set_filled;
    logic              clr_filled;
    logic              load_out;
    logic              out_last;
  } dp_cmd_t;

  typedef struct packed {
    logic rd_zero;
    logic y_nz;
    logic n_zero;
    logic d_zero;
    logic mul_done;
    logic div_done;
  } dp_sts_t;

endpackage

[rtl/rmvi_if.sv]
`timescale 1ns / 1ps
// item channels of the regression imputer
interface rmvi_in_if;
  import rmvi_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [CELL_W-1:0] cell_value;
  modport source (output valid, output cell_value, input ready);
  modport sink (input valid, input cell_value, output ready);
endinterface

interface rmvi_out_if;
  import rmvi_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [CELL_W-1:0] result_value;
  logic                     was_imputed;
  logic                     final_cell;
  modport source (output valid, output result_value, output was_imputed,
                  output final_cell, input ready);
  modport sink (input valid, input result_value, input was_imputed,
                input final_cell, output ready);
endinterface

[rtl/rmvi_ram.sv]
`timescale 1ns / 1ps
// generic single-port ram with registered read
module rmvi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 40
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

[rtl/rmvi_mul.sv]
`timescale 1ns / 1ps
// shift-add signed multiplier, one multiplier bit per cycle
module rmvi_mul (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic signed [rmvi_pkg::WIDE_W-1:0] a_i,
  input  logic signed [rmvi_pkg::WIDE_W-1:0] b_i,
  output logic                               done_o,
  output logic signed [rmvi_pkg::WIDE_W-1:0] product_o
);
  import rmvi_pkg::*;

  logic              busy_q;
  logic              neg_q;
  logic [WIDE_W-1:0] mcand_q, mplier_q, acc_q;
  logic [WIDE_W-1:0] abs_a, abs_b;

  assign abs_a     = a_i[WIDE_W-1] ? WIDE_W'(-a_i) : WIDE_W'(a_i);
  assign abs_b     = b_i[WIDE_W-1] ? WIDE_W'(-b_i) : WIDE_W'(b_i);
  assign done_o    = busy_q && (mplier_q == '0);
  assign product_o = neg_q ? -signed'(acc_q) : signed'(acc_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (start_i) begin
      busy_q <= 1'b1;
    end else if (done_o) begin
      busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q    <= a_i[WIDE_W-1] ^ b_i[WIDE_W-1];
      mcand_q  <= abs_a;
      mplier_q <= abs_b;
      acc_q    <= '0;
    end else if (busy_q && (mplier_q != '0)) begin
      if (mplier_q[0]) begin
        acc_q <= acc_q + mcand_q;
      end
      mcand_q  <= {mcand_q[WIDE_W-2:0], 1'b0};
      mplier_q <= {1'b0, mplier_q[WIDE_W-1:1]};
    end
  end
endmodule

[rtl/rmvi_div.sv]
`timescale 1ns / 1ps
// restoring signed divider, one quotient bit per cycle, saturating result
module rmvi_div (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic signed [rmvi_pkg::WIDE_W-1:0] num_i,
  input  logic signed [rmvi_pkg::WIDE_W-1:0] den_i,
  output logic                               done_o,
  output logic signed [rmvi_pkg::CELL_W-1:0] quo_o
);
  import rmvi_pkg::*;

  logic              busy_q;
  logic              neg_q;
  logic [DCNT_W-1:0] cnt_q;
  logic [WIDE_W-1:0] num_q, den_q, rem_q;
  logic [WIDE_W:0]   rem_sh, rem_nx;
  logic              ge;
  logic [CELL_W:0]   lim, mag, res;
  logic              over;

  assign done_o = busy_q && (cnt_q == '0);
  assign rem_sh = {rem_q, num_q[WIDE_W-1]};
  assign ge     = rem_sh >= {1'b0, den_q};
  assign rem_nx = ge ? rem_sh - {1'b0, den_q} : rem_sh;
  assign lim    = neg_q ? {2'b01, {(CELL_W-1){1'b0}}} : {2'b00, {(CELL_W-1){1'b1}}};
  assign over   = num_q > WIDE_W'(lim);
  assign mag    = over ? lim : num_q[CELL_W:0];
  assign res    = neg_q ? -mag : mag;
  assign quo_o  = signed'(res[CELL_W-1:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= DCNT_W'(WIDE_W);
    end else if (done_o) begin
      busy_q <= 1'b0;
    end else if (busy_q) begin
      cnt_q <= cnt_q - DCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= num_i[WIDE_W-1] ^ den_i[WIDE_W-1];
      num_q <= num_i[WIDE_W-1] ? WIDE_W'(-num_i) : WIDE_W'(num_i);
      den_q <= den_i[WIDE_W-1] ? WIDE_W'(-den_i) : WIDE_W'(den_i);
      rem_q <= '0;
    end else if (busy_q && (cnt_q != '0)) begin
      rem_q <= rem_nx[WIDE_W-1:0];
      num_q <= {num_q[WIDE_W-2:0], ge};
    end
  end
endmodule

[rtl/rmvi_dp.sv]
`timescale 1ns / 1ps
// datapath: cell store, fit sums, shared multiplier and divider, output register
module rmvi_dp (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  rmvi_pkg::dp_cmd_t                  cmd_i,
  input  logic signed [rmvi_pkg::CELL_W-1:0] cell_value_i,
  output rmvi_pkg::dp_sts_t                  sts_o,
  output logic signed [rmvi_pkg::CELL_W-1:0] result_value_o,
  output logic                               was_imputed_o,
  output logic                               final_cell_o
);
  import rmvi_pkg::*;

  logic [CELL_W-1:0]        wdata, rdata;
  logic signed [CELL_W-1:0] y_q, x_q, xr_q;
  logic signed [SUM_W-1:0]  sx_q, sy_q;
  logic [ROW_W-1:0]         n_q;
  logic signed [WIDE_W-1:0] sxy_q, sxx_q, tmp_q, d_q, nn_q, t_q, num_q, den_q;
  logic signed [WIDE_W-1:0] op_a, op_b, prod;
  logic signed [WIDE_W-1:0] n_w;
  logic signed [CELL_W-1:0] quo;
  logic                     mul_done, div_done;
  logic [CELLS-1:0]         filled_q;

  assign wdata = (cmd_i.wsel == WSEL_IN) ? cell_value_i : quo;

  rmvi_ram #(.WIDTH(CELL_W), .DEPTH(CELLS)) u_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.ram_we),
    .addr_i  (cmd_i.ram_addr),
    .wdata_i (wdata),
    .rdata_o (rdata)
  );

  assign n_w = signed'(WIDE_W'(n_q));

  always_comb begin
    case (cmd_i.mop)
      MOP_XY:   begin op_a = WIDE_W'(x_q);  op_b = WIDE_W'(y_q);  end
      MOP_XX:   begin op_a = WIDE_W'(x_q);  op_b = WIDE_W'(x_q);  end
      MOP_NSXX: begin op_a = sxx_q;         op_b = n_w;           end
      MOP_SXSX: begin op_a = WIDE_W'(sx_q); op_b = WIDE_W'(sx_q); end
      MOP_NSXY: begin op_a = sxy_q;         op_b = n_w;           end
      MOP_SXSY: begin op_a = WIDE_W'(sx_q); op_b = WIDE_W'(sy_q); end
      MOP_NXR:  begin op_a = WIDE_W'(xr_q); op_b = n_w;           end
      MOP_NT:   begin op_a = nn_q;          op_b = t_q;           end
      MOP_SYD:  begin op_a = d_q;           op_b = WIDE_W'(sy_q); end
      MOP_ND:   begin op_a = d_q;           op_b = n_w;           end
      default:  begin op_a = '0;            op_b = '0;            end
    endcase
  end

  rmvi_mul u_mul (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cmd_i.mul_start),
    .a_i       (op_a),
    .b_i       (op_b),
    .done_o    (mul_done),
    .product_o (prod)
  );

  rmvi_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (num_q),
    .den_i   (den_q),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  always_ff @(posedge clk_i) begin
    case (cmd_i.cap)
      CAP_Y:   y_q  <= signed'(rdata);
      CAP_X:   x_q  <= signed'(rdata);
      CAP_XR:  xr_q <= signed'(rdata);
      default: ;
    endcase
    if (cmd_i.clr_fit) begin
      sx_q  <= '0;
      sy_q  <= '0;
      n_q   <= '0;
      sxy_q <= '0;
      sxx_q <= '0;
    end else if (cmd_i.acc_row) begin
      sx_q <= sx_q + SUM_W'(x_q);
      sy_q <= sy_q + SUM_W'(y_q);
      n_q  <= n_q + ROW_W'(1);
    end
    case (cmd_i.wb)
      WB_SXY:  sxy_q <= sxy_q + prod;
      WB_SXX:  sxx_q <= sxx_q + prod;
      WB_TMP:  tmp_q <= prod;
      WB_DSUB: d_q   <= tmp_q - prod;
      WB_NSUB: nn_q  <= tmp_q - prod;
      WB_T:    t_q   <= prod - WIDE_W'(sx_q);
      WB_NUM:  num_q <= tmp_q + prod;
      WB_DEN:  den_q <= prod;
      default: ;
    endcase
    if (cmd_i.load_out) begin
      result_value_o <= signed'(rdata);
      was_imputed_o  <= filled_q[cmd_i.ram_addr];
      final_cell_o   <= cmd_i.out_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filled_q <= '0;
    end else if (cmd_i.clr_filled) begin
      filled_q <= '0;
    end else if (cmd_i.set_filled) begin
      filled_q[cmd_i.ram_addr] <= 1'b1;
    end
  end

  assign sts_o.rd_zero  = rdata == '0;
  assign sts_o.y_nz     = y_q != '0;
  assign sts_o.n_zero   = n_q == '0;
  assign sts_o.d_zero   = d_q == '0;
  assign sts_o.mul_done = mul_done;
  assign sts_o.div_done = div_done;
endmodule

[rtl/rmvi_ctrl.sv]
`timescale 1ns / 1ps
// controller: load, per-cell fit sequencing and emission
module rmvi_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  input  logic [rmvi_pkg::ROW_W-1:0]   rows_i,
  input  logic [rmvi_pkg::CNT_W-1:0]   total_i,
  input  rmvi_pkg::dp_sts_t            sts_i,
  output rmvi_pkg::dp_cmd_t            cmd_o
);
  import rmvi_pkg::*;

  typedef enum logic [19:0] {
    S_LOAD   = 20'h00001,
    S_CRD    = 20'h00002,
    S_CCAP   = 20'h00004,
    S_RY     = 20'h00008,
    S_RX     = 20'h00010,
    S_CX     = 20'h00020,
    S_ROW    = 20'h00040,
    S_MXY    = 20'h00080,
    S_MXX    = 20'h00100,
    S_RNEXT  = 20'h00200,
    S_FXRD   = 20'h00400,
    S_FXCAP  = 20'h00800,
    S_MSTART = 20'h01000,
    S_MWAIT  = 20'h02000,
    S_DIV    = 20'h04000,
    S_DWAIT  = 20'h08000,
    S_NEXT   = 20'h10000,
    S_ERD    = 20'h20000,
    S_ELD    = 20'h40000,
    S_EHOLD  = 20'h80000
  } state_e;

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  lp_q, lp_d;
  logic [ADDR_W-1:0] idx_q, idx_d, jb_q, jb_d;
  logic [COL_W-1:0]  col_q, col_d, nx;
  logic [ROW_W-1:0]  j_q, j_d;
  logic [2:0]        step_q, step_d;
  logic              out_valid_q, out_valid_d;
  logic [CNT_W-1:0]  slot;
  logic              in_fire, last_slot, last_idx;
  mop_e              step_mop;
  wb_e               step_wb;

  assign nx        = (col_q == COL_W'(NUM_ATTRIBUTES - 1)) ? '0 : col_q + COL_W'(1);
  assign slot      = (lp_q < total_i) ? lp_q : total_i - CNT_W'(1);
  assign in_fire   = in_valid_i && in_ready_o;
  assign last_slot = (slot + CNT_W'(1)) >= total_i;
  assign last_idx  = CNT_W'(idx_q) == (total_i - CNT_W'(1));
  assign in_ready_o  = state_q == S_LOAD;
  assign out_valid_o = out_valid_q;

  always_comb begin
    case (step_q)
      3'd0:    begin step_mop = MOP_NSXX; step_wb = WB_TMP;  end
      3'd1:    begin step_mop = MOP_SXSX; step_wb = WB_DSUB; end
      3'd2:    begin step_mop = MOP_NSXY; step_wb = WB_TMP;  end
      3'd3:    begin step_mop = MOP_SXSY; step_wb = WB_NSUB; end
      3'd4:    begin step_mop = MOP_NXR;  step_wb = WB_T;    end
      3'd5:    begin step_mop = MOP_NT;   step_wb = WB_TMP;  end
      3'd6:    begin step_mop = MOP_SYD;  step_wb = WB_NUM;  end
      default: begin step_mop = MOP_ND;   step_wb = WB_DEN;  end
    endcase
  end

  always_comb begin
    state_d     = state_q;
    lp_d        = lp_q;
    idx_d       = idx_q;
    jb_d        = jb_q;
    col_d       = col_q;
    j_d         = j_q;
    step_d      = step_q;
    out_valid_d = out_valid_q;
    cmd_o            = '0;
    cmd_o.wsel       = WSEL_QUO;
    cmd_o.ram_addr   = idx_q;
    cmd_o.cap        = CAP_NONE;
    cmd_o.mop        = MOP_XY;
    cmd_o.wb         = WB_NONE;
    case (state_q)
      S_LOAD: begin
        cmd_o.wsel     = WSEL_IN;
        cmd_o.ram_addr = slot[ADDR_W-1:0];
        if (in_fire) begin
          cmd_o.ram_we = 1'b1;
          if (last_slot) begin
            lp_d             = '0;
            idx_d            = '0;
            col_d            = '0;
            cmd_o.clr_filled = 1'b1;
            state_d          = S_CRD;
          end else begin
            lp_d = slot + CNT_W'(1);
          end
        end
      end
      S_CRD: state_d = S_CCAP;
      S_CCAP: begin
        if (sts_i.rd_zero) begin
          cmd_o.clr_fit = 1'b1;
          j_d           = '0;
          jb_d          = '0;
          state_d       = S_RY;
        end else begin
          state_d = S_NEXT;
        end
      end
      S_RY: begin
        cmd_o.ram_addr = jb_q + ADDR_W'(col_q);
        state_d        = S_RX;
      end
      S_RX: begin
        cmd_o.ram_addr = jb_q + ADDR_W'(nx);
        cmd_o.cap      = CAP_Y;
        state_d        = S_CX;
      end
      S_CX: begin
        cmd_o.cap = CAP_X;
        state_d   = S_ROW;
      end
      S_ROW: begin
        if (sts_i.y_nz) begin
          cmd_o.acc_row   = 1'b1;
          cmd_o.mul_start = 1'b1;
          cmd_o.mop       = MOP_XY;
          state_d         = S_MXY;
        end else begin
          state_d = S_RNEXT;
        end
      end
      S_MXY: begin
        cmd_o.mop = MOP_XX;
        if (sts_i.mul_done) begin
          cmd_o.wb        = WB_SXY;
          cmd_o.mul_start = 1'b1;
          state_d         = S_MXX;
        end
      end
      S_MXX: begin
        if (sts_i.mul_done) begin
          cmd_o.wb = WB_SXX;
          state_d  = S_RNEXT;
        end
      end
      S_RNEXT: begin
        if (j_q == rows_i - ROW_W'(1)) begin
          state_d = S_FXRD;
        end else begin
          j_d     = j_q + ROW_W'(1);
          jb_d    = jb_q + ADDR_W'(NUM_ATTRIBUTES);
          state_d = S_RY;
        end
      end
      S_FXRD: begin
        cmd_o.ram_addr = idx_q - ADDR_W'(col_q) + ADDR_W'(nx);
        state_d        = S_FXCAP;
      end
      S_FXCAP: begin
        cmd_o.cap = CAP_XR;
        step_d    = '0;
        state_d   = sts_i.n_zero ? S_NEXT : S_MSTART;
      end
      S_MSTART: begin
        cmd_o.mop = step_mop;
        if ((step_q == 3'd2) && sts_i.d_zero) begin
          state_d = S_NEXT;
        end else begin
          cmd_o.mul_start = 1'b1;
          state_d         = S_MWAIT;
        end
      end
      S_MWAIT: begin
        cmd_o.mop = step_mop;
        if (sts_i.mul_done) begin
          cmd_o.wb = step_wb;
          if (step_q == 3'd7) begin
            state_d = S_DIV;
          end else begin
            step_d  = step_q + 3'd1;
            state_d = S_MSTART;
          end
        end
      end
      S_DIV: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_DWAIT;
      end
      S_DWAIT: begin
        if (sts_i.div_done) begin
          cmd_o.ram_we     = 1'b1;
          cmd_o.set_filled = 1'b1;
          state_d          = S_NEXT;
        end
      end
      S_NEXT: begin
        if (last_idx) begin
          idx_d   = '0;
          state_d = S_ERD;
        end else begin
          idx_d   = idx_q + ADDR_W'(1);
          col_d   = nx;
          state_d = S_CRD;
        end
      end
      S_ERD: state_d = S_ELD;
      S_ELD: begin
        cmd_o.load_out = 1'b1;
        cmd_o.out_last = last_idx;
        out_valid_d    = 1'b1;
        state_d        = S_EHOLD;
      end
      S_EHOLD: begin
        if (out_ready_i) begin
          out_valid_d = 1'b0;
          if (last_idx) begin
            idx_d   = '0;
            state_d = S_LOAD;
          end else begin
            idx_d   = idx_q + ADDR_W'(1);
            state_d = S_ERD;
          end
        end
      end
      default: state_d = S_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_LOAD;
      lp_q        <= '0;
      idx_q       <= '0;
      jb_q        <= '0;
      col_q       <= '0;
      j_q         <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      lp_q        <= lp_d;
      idx_q       <= idx_d;
      jb_q        <= jb_d;
      col_q       <= col_d;
      j_q         <= j_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_no_load_while_emitting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o)
    else $error("input taken while a result is pending");

  a_full_set_starts_fit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && last_slot |=> state_q == S_CRD && idx_q == '0)
    else $error("completed set did not start the fit pass");

  a_last_result_reloads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && last_idx |=> state_q == S_LOAD && lp_q == '0)
    else $error("final result did not return to loading");

  a_store_write_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.ram_we |-> state_q == S_LOAD || (state_q == S_DWAIT && sts_i.div_done))
    else $error("cell store written outside load or imputation");
endmodule

[rtl/regression_missing_value_imputer_top.sv]
`timescale 1ns / 1ps
// regression imputer top level: configuration register, controller and datapath
// load: one cell per cycle; no result until the last cell of the set arrives
// fit: per missing cell a pass over every record, with shift-add multiplies for each record whose
//   cell is nonzero, then more shift-add multiplies and a restoring divide; other cells are skipped
// emission: each result is registered and held until the sink takes it; input stalls from set end to last result
// reset: record_count 8, load position 0, cell store contents undefined until loaded
module regression_missing_value_imputer_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rmvi_pkg::APB_AW-1:0]   paddr,
  input  logic [rmvi_pkg::APB_DW-1:0]   pwdata,
  output logic [rmvi_pkg::APB_DW-1:0]   prdata,
  output logic                          pready,
  rmvi_in_if.sink                       in_ch,
  rmvi_out_if.source                    out_ch
);
  import rmvi_pkg::*;

  logic [CFG_W-1:0]  record_count_q;
  logic [ROW_W-1:0]  rows;
  logic [CNT_W-1:0]  total;
  logic              reg_hit;
  dp_cmd_t           cmd;
  dp_sts_t           sts;

  assign pready  = 1'b1;
  assign reg_hit = paddr[APB_AW-1:2] == REG_RECORD_COUNT;
  assign prdata  = reg_hit ? APB_DW'(record_count_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      record_count_q <= RECORD_COUNT_RST;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      record_count_q <= pwdata[CFG_W-1:0];
    end
  end

  always_comb begin
    if (record_count_q == '0) begin
      rows = ROW_W'(1);
    end else if (32'(record_count_q) > MAX_RECORDS) begin
      rows = ROW_W'(MAX_RECORDS);
    end else begin
      rows = ROW_W'(record_count_q);
    end
  end

  assign total = CNT_W'(32'(rows) * NUM_ATTRIBUTES);

  rmvi_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_ch.valid),
    .in_ready_o  (in_ch.ready),
    .out_valid_o (out_ch.valid),
    .out_ready_i (out_ch.ready),
    .rows_i      (rows),
    .total_i     (total),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  rmvi_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .cell_value_i   (in_ch.cell_value),
    .sts_o          (sts),
    .result_value_o (out_ch.result_value),
    .was_imputed_o  (out_ch.was_imputed),
    .final_cell_o   (out_ch.final_cell)
  );
endmodule

[test/regression_missing_value_imputer_top_tb.sv]
`timescale 1ns / 1ps
// self-checking testbench of the regression imputer: random cell sets, idle gaps, config changes
module regression_missing_value_imputer_top_tb;
  import rmvi_pkg::*;

  typedef struct packed {
    logic [CELL_W-1:0] value;
    logic              imputed;
    logic              last;
  } cell_result_t;

  logic clk_i;
  logic rst_ni;
  logic psel;
  logic penable;
  logic pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic pready;

  rmvi_in_if  in_ch ();
  rmvi_out_if out_ch ();

  regression_missing_value_imputer_top u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_ch   (in_ch.sink),
    .out_ch  (out_ch.source)
  );

  logic signed [CELL_W-1:0] table_cells [CELLS];
  int unsigned              fill_pos;
  logic [CFG_W-1:0]         rows_reg;
  logic [CELL_W-1:0]        cells_to_send [$];
  cell_result_t             expected_cells [$];
  int                       errors;
  int                       sent_count;
  int                       in_gap;
  int                       out_gap;
  int                       hold_cnt;
  bit                       held_once;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic int active_rows();
    if (rows_reg == 0) return 1;
    if (rows_reg > MAX_RECORDS) return MAX_RECORDS;
    return int'(rows_reg);
  endfunction

  // least-squares fit of column col against the next column, written in place
  function automatic bit fit_cell(int rows, int row, int col);
    int nx;
    logic signed [127:0] sx, sy, sxy, sxx, n, x, y, d, nn, num, den, q;
    nx = (col + 1) % NUM_ATTRIBUTES;
    sx = 0; sy = 0; sxy = 0; sxx = 0; n = 0;
    for (int j = 0; j < rows; j++) begin
      y = table_cells[j * NUM_ATTRIBUTES + col];
      x = table_cells[j * NUM_ATTRIBUTES + nx];
      if (y != 0) begin
        sx += x;
        sy += y;
        sxy += x * y;
        sxx += x * x;
        n += 1;
      end
    end
    if (n == 0) return 1'b0;
    d = n * sxx - sx * sx;
    if (d == 0) return 1'b0;
    nn = n * sxy - sx * sy;
    x = table_cells[row * NUM_ATTRIBUTES + nx];
    num = nn * (n * x - sx) + sy * d;
    den = n * d;
    q = num / den;
    if (q > 128'sh7FFFFFFF) q = 128'sh7FFFFFFF;
    if (q < -128'sh80000000) q = -128'sh80000000;
    table_cells[row * NUM_ATTRIBUTES + col] = q[CELL_W-1:0];
    return 1'b1;
  endfunction

  task automatic load_cell(logic [CELL_W-1:0] v);
    int rows, total, slot;
    bit filled [CELLS];
    cell_result_t r;
    rows = active_rows();
    total = rows * NUM_ATTRIBUTES;
    slot = (fill_pos < total) ? fill_pos : total - 1;
    table_cells[slot] = v;
    fill_pos = slot + 1;
    if (fill_pos < total) return;
    fill_pos = 0;
    for (int k = 0; k < total; k++) begin
      filled[k] = 1'b0;
      if (table_cells[k] == 0) filled[k] = fit_cell(rows, k / NUM_ATTRIBUTES, k % NUM_ATTRIBUTES);
    end
    for (int k = 0; k < total; k++) begin
      r.value = table_cells[k];
      r.imputed = filled[k];
      r.last = (k + 1 == total);
      expected_cells.push_back(r);
    end
  endtask

  // sender
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
      in_ch.cell_value <= '0;
      in_gap <= 0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_ch.valid <= 1'b0;
      end else if (cells_to_send.size() > 0) begin
        in_ch.cell_value <= cells_to_send.pop_front();
        in_ch.valid <= 1'b1;
        in_gap <= pick_gap();
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_ch.valid && in_ch.ready) load_cell(in_ch.cell_value);
  end

  // long receiver hold-off, once, while results are pending and items still wait
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_cnt <= 0;
      held_once <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
    end else if (!held_once && out_ch.valid && cells_to_send.size() > 0) begin
      hold_cnt <= 600;
      held_once <= 1'b1;
    end
  end

  // receiver and checker
  always @(posedge clk_i or negedge rst_ni) begin
    cell_result_t e;
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
      out_gap <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_cells.size() == 0) begin
          $display("%0t: unexpected result %h", $time, out_ch.result_value);
          errors++;
        end else begin
          e = expected_cells.pop_front();
          if (out_ch.result_value !== e.value || out_ch.was_imputed !== e.imputed ||
              out_ch.final_cell !== e.last) begin
            $display("%0t: mismatch expected %h/%b/%b actual %h/%b/%b", $time,
                     e.value, e.imputed, e.last, out_ch.result_value,
                     out_ch.was_imputed, out_ch.final_cell);
            errors++;
          end
        end
      end
      if (hold_cnt > 0) begin
        out_ch.ready <= 1'b0;
      end else if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        out_gap <= pick_gap();
      end
    end
  end

  task automatic write_rows(logic [CFG_W-1:0] v);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {REG_RECORD_COUNT, 2'b00};
    pwdata <= APB_DW'(v);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    rows_reg = v;
  endtask

  task automatic wait_drained();
    while (cells_to_send.size() > 0 || expected_cells.size() > 0 || in_ch.valid)
      @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  function automatic logic [CELL_W-1:0] random_cell();
    int r;
    r = $urandom_range(0, 9);
    if (r < 3) return '0;
    if (r < 5) return $urandom;
    return CELL_W'($signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000);
  endfunction

  task automatic push_set();
    int total;
    total = active_rows() * NUM_ATTRIBUTES;
    for (int k = 0; k < total; k++) cells_to_send.push_back(random_cell());
    sent_count += total;
  endtask

  initial begin
    logic [CELL_W-1:0] directed [20];
    logic [CFG_W-1:0] rc;
    directed = '{
      32'h7FFFFFFF, 32'h80000000, 32'h0, 32'h00010000, 32'h0,
      32'h80000000, 32'h7FFFFFFF, 32'h0, 32'h00010000, 32'h5,
      32'h0,        32'h1,        32'h0, 32'h00010000, 32'hFFFFFFFF,
      32'h00020000, 32'h0,        32'h0, 32'h00010000, 32'h3};
    errors = 0;
    sent_count = 0;
    fill_pos = 0;
    rows_reg = RECORD_COUNT_RST;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    rst_ni = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_rows(4);
    foreach (directed[k]) cells_to_send.push_back(directed[k]);
    sent_count += 20;
    wait_drained();
    write_rows(0);
    cells_to_send.push_back(32'h0);
    cells_to_send.push_back(32'hFFFF0000);
    cells_to_send.push_back(32'h0);
    cells_to_send.push_back(32'h12345678);
    cells_to_send.push_back(32'h0);
    sent_count += 5;
    wait_drained();
    write_rows(15);
    push_set();
    push_set();
    wait_drained();

    while (sent_count < 250) begin
      case ($urandom_range(0, 11))
        0: rc = 0;
        1: rc = CFG_W'($urandom_range(9, 15));
        2: rc = 8;
        default: rc = CFG_W'($urandom_range(1, 3));
      endcase
      write_rows(rc);
      repeat ($urandom_range(1, 2)) push_set();
      wait_drained();
    end

    repeat (200) @(posedge clk_i);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
